@@ hw/rtl/vpcd_pkg.sv @@
// ---------------------------------------------------------------------------
// vpcd_pkg
// Shared codes, types and constants of the vector picture command decoder.
// ---------------------------------------------------------------------------
package vpcd_pkg;

    // command stream codes
    localparam logic [7:0] CODE_ABS_LINE = 8'hF6;
    localparam logic [7:0] CODE_REL_LINE = 8'hF7;
    localparam logic [7:0] CODE_PLOT     = 8'hFA;
    localparam logic [7:0] CODE_FILL     = 8'hF8;
    localparam logic [7:0] CODE_END      = 8'hFF;

    // drawing command in progress
    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_ABS,
        CMD_REL,
        CMD_PLOT,
        CMD_FILL
    } t_cmd;

    // primitive opcode on the output
    typedef enum logic [1:0] {
        OP_LINE,
        OP_PLOT,
        OP_FILL,
        OP_END
    } t_op;

    // class the front end gives each byte
    typedef enum logic [2:0] {
        KIND_DATA,
        KIND_END,
        KIND_ABS,
        KIND_REL,
        KIND_PLOT,
        KIND_FILL
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] code;
    } t_token;

    typedef struct packed {
        t_op        opcode;
        logic [7:0] x_from;
        logic [7:0] y_from;
        logic [7:0] x_to;
        logic [7:0] y_to;
    } t_prim;

    typedef struct packed {
        logic head_valid;
        logic full;
    } t_q_status;

endpackage

@@ hw/rtl/vpcd_byte_if.sv @@
// ---------------------------------------------------------------------------
// vpcd_byte_if
// Valid/ready channel carrying one byte of the picture command stream.
// ---------------------------------------------------------------------------
interface vpcd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;

    modport source (output valid, output code_byte, input ready);
    modport sink (input valid, input code_byte, output ready);
endinterface

@@ hw/rtl/vpcd_prim_if.sv @@
// ---------------------------------------------------------------------------
// vpcd_prim_if
// Valid/ready channel carrying one decoded drawing primitive.
// ---------------------------------------------------------------------------
interface vpcd_prim_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] x_from;
    logic [7:0] y_from;
    logic [7:0] x_to;
    logic [7:0] y_to;

    modport source (
        output valid, output opcode, output x_from, output y_from,
        output x_to, output y_to, input ready
    );
    modport sink (
        input valid, input opcode, input x_from, input y_from,
        input x_to, input y_to, output ready
    );
endinterface

@@ hw/rtl/vector_picture_command_decoder.sv @@
// ---------------------------------------------------------------------------
// vector_picture_command_decoder
// Turns a vector picture byte stream into line, plot, fill and end items.
// ---------------------------------------------------------------------------
// Takes one command stream byte per cycle while the queue is not full and
// gives at most one drawing primitive per byte. A byte is classified on entry
// and waits in a two-entry queue; the back end takes one byte per cycle from
// it unless the byte's primitive meets a full output register not being taken,
// updates the argument slots and pen in that same cycle and loads the output
// register, so a primitive reaches o_prim through its queue entry and then
// the output register. The sustained rate is one byte per cycle, set by the
// back end's state update, for as long as o_prim is taken when offered;
// bytes that give no primitive move on even while the output register is full.
module vector_picture_command_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vpcd_byte_if.sink   i_code,
    vpcd_prim_if.source o_prim
);

    vpcd_pkg::t_q_status w_qstat;
    vpcd_pkg::t_token    w_token;
    vpcd_pkg::t_token    w_head;
    logic                w_push;
    logic                w_pop;

    vpcd_front u_front (
        .i_code  (i_code),
        .i_qstat (w_qstat),
        .o_push  (w_push),
        .o_token (w_token)
    );

    vpcd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_token  (w_token),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_qstat)
    );

    vpcd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_qstat (w_qstat),
        .o_pop   (w_pop),
        .o_prim  (o_prim)
    );

`ifndef SYNTHESIS
    a_pop_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_qstat.head_valid)
        else $error("back end popped an empty queue");

    a_end_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_prim.valid && o_prim.opcode == vpcd_pkg::OP_END |->
            o_prim.x_from == 8'd0 && o_prim.y_from == 8'd0 &&
            o_prim.x_to == 8'd0 && o_prim.y_to == 8'd0)
        else $error("end of picture item carries nonzero coordinates");

    a_point_no_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_prim.valid &&
        (o_prim.opcode == vpcd_pkg::OP_PLOT || o_prim.opcode == vpcd_pkg::OP_FILL) |->
            o_prim.x_to == 8'd0 && o_prim.y_to == 8'd0)
        else $error("plot or fill item carries an end point");

    a_full_then_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.full && !w_pop |=> w_qstat.full)
        else $error("queue lost an entry without a pop");
`endif

endmodule

@@ hw/rtl/vpcd_front.sv @@
// ---------------------------------------------------------------------------
// vpcd_front
// Accepts command stream bytes and tags each one with its byte class.
// ---------------------------------------------------------------------------
module vpcd_front (
    vpcd_byte_if.sink           i_code,
    input  vpcd_pkg::t_q_status i_qstat,
    output logic                o_push,
    output vpcd_pkg::t_token    o_token
);

    assign i_code.ready = !i_qstat.full;
    assign o_push       = i_code.valid && !i_qstat.full;

    always_comb begin
        o_token.code = i_code.code_byte;
        unique case (i_code.code_byte)
            vpcd_pkg::CODE_END:      o_token.kind = vpcd_pkg::KIND_END;
            vpcd_pkg::CODE_ABS_LINE: o_token.kind = vpcd_pkg::KIND_ABS;
            vpcd_pkg::CODE_REL_LINE: o_token.kind = vpcd_pkg::KIND_REL;
            vpcd_pkg::CODE_PLOT:     o_token.kind = vpcd_pkg::KIND_PLOT;
            vpcd_pkg::CODE_FILL:     o_token.kind = vpcd_pkg::KIND_FILL;
            default:                 o_token.kind = vpcd_pkg::KIND_DATA;
        endcase
    end

endmodule

@@ hw/rtl/vpcd_queue.sv @@
// ---------------------------------------------------------------------------
// vpcd_queue
// Two-entry queue of classified bytes between the front and back ends.
// ---------------------------------------------------------------------------
module vpcd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  vpcd_pkg::t_token    i_token,
    input  logic                i_pop,
    output vpcd_pkg::t_token    o_head,
    output vpcd_pkg::t_q_status o_status
);

    localparam int Depth = 2;
    localparam int PtrW  = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);

    vpcd_pkg::t_token r_mem [Depth];
    logic [PtrW-1:0]  r_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr;
    logic [CntW-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PtrW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PtrW'(1);
            end
            r_count <= r_count + CntW'(i_push) - CntW'(i_pop);
        end
    end

    assign o_head              = r_mem[r_rd_ptr];
    assign o_status.head_valid = (r_count != '0);
    assign o_status.full       = (r_count == CntW'(Depth));

endmodule

@@ hw/rtl/vpcd_back.sv @@
// ---------------------------------------------------------------------------
// vpcd_back
// Runs the argument collector and pen state, and registers each primitive.
// ---------------------------------------------------------------------------
module vpcd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  vpcd_pkg::t_token    i_head,
    input  vpcd_pkg::t_q_status i_qstat,
    output logic                o_pop,
    vpcd_prim_if.source         o_prim
);

    localparam int Slots = 4;

    vpcd_pkg::t_cmd  r_cmd, n_cmd;
    logic [2:0]      r_wanted, n_wanted;
    logic [2:0]      r_taken, n_taken;
    logic [2:0]      r_idx, n_idx;
    logic [7:0]      r_slots [Slots];
    logic [7:0]      n_slots [Slots];
    logic [7:0]      r_pen_x, n_pen_x;
    logic [7:0]      r_pen_y, n_pen_y;
    vpcd_pkg::t_prim r_out, w_res;
    logic            r_out_valid;
    logic            w_res_valid;
    logic [7:0]      w_move_y;
    logic [7:0]      w_move_x;

    // bit 3 is the sign, bits 2..0 the magnitude
    function automatic logic [7:0] nibble_move(input logic [7:0] base,
                                               input logic [3:0] nib);
        if (nib[3]) begin
            return base - {5'd0, nib[2:0]};
        end
        return base + {5'd0, nib[2:0]};
    endfunction

    assign w_move_y = nibble_move(r_pen_y, i_head.code[3:0]);
    assign w_move_x = nibble_move(r_pen_x, i_head.code[7:4]);

    always_comb begin
        n_cmd       = r_cmd;
        n_wanted    = r_wanted;
        n_taken     = r_taken;
        n_idx       = r_idx;
        n_slots     = r_slots;
        n_pen_x     = r_pen_x;
        n_pen_y     = r_pen_y;
        w_res       = '0;
        w_res_valid = 1'b0;

        if (i_head.kind == vpcd_pkg::KIND_END) begin
            n_cmd       = vpcd_pkg::CMD_NONE;
            n_wanted    = '0;
            n_taken     = '0;
            n_idx       = '0;
            n_slots     = '{default: '0};
            n_pen_x     = '0;
            n_pen_y     = '0;
            w_res.opcode = vpcd_pkg::OP_END;
            w_res_valid = 1'b1;
        end else if (i_head.kind != vpcd_pkg::KIND_DATA && r_taken == '0) begin
            unique case (i_head.kind)
                vpcd_pkg::KIND_ABS: begin
                    n_pen_x  = '0;
                    n_pen_y  = '0;
                    n_cmd    = vpcd_pkg::CMD_ABS;
                    n_wanted = 3'd4;
                    n_idx    = '0;
                end
                vpcd_pkg::KIND_REL: begin
                    // line starts at the current pen
                    n_cmd      = vpcd_pkg::CMD_REL;
                    n_wanted   = 3'd1;
                    n_slots[0] = r_pen_y;
                    n_slots[1] = r_pen_x;
                    n_idx      = 3'd2;
                end
                vpcd_pkg::KIND_PLOT: begin
                    n_pen_x  = '0;
                    n_pen_y  = '0;
                    n_cmd    = vpcd_pkg::CMD_PLOT;
                    n_wanted = 3'd2;
                    n_idx    = '0;
                end
                vpcd_pkg::KIND_FILL: begin
                    n_pen_x  = '0;
                    n_pen_y  = '0;
                    n_cmd    = vpcd_pkg::CMD_FILL;
                    n_wanted = 3'd3;
                    n_idx    = '0;
                end
                default: begin
                end
            endcase
        end else begin
            // every other byte is argument data
            if (r_taken < r_wanted) begin
                if (r_cmd == vpcd_pkg::CMD_REL) begin
                    if (n_idx < 3'(Slots)) begin
                        n_slots[n_idx[1:0]] = w_move_y;
                        n_idx = n_idx + 3'd1;
                    end
                    if (n_idx < 3'(Slots)) begin
                        n_slots[n_idx[1:0]] = w_move_x;
                        n_idx = n_idx + 3'd1;
                    end
                    n_taken = r_taken + 3'd2;
                end else begin
                    if (n_idx < 3'(Slots)) begin
                        n_slots[n_idx[1:0]] = i_head.code;
                        n_idx = n_idx + 3'd1;
                    end
                    n_taken = r_taken + 3'd1;
                end
            end

            if (!(n_taken < n_wanted)) begin
                unique case (r_cmd)
                    vpcd_pkg::CMD_ABS, vpcd_pkg::CMD_REL: begin
                        w_res.opcode = vpcd_pkg::OP_LINE;
                        w_res.x_from = n_slots[1];
                        w_res.y_from = n_slots[0];
                        w_res.x_to   = n_slots[3];
                        w_res.y_to   = n_slots[2];
                        w_res_valid  = 1'b1;
                        // chain the next line from this end point
                        n_pen_x    = n_slots[3];
                        n_pen_y    = n_slots[2];
                        n_slots[0] = n_slots[2];
                        n_slots[1] = n_slots[3];
                        n_taken    = '0;
                        n_idx      = 3'd2;
                        n_wanted   = 3'd2;
                    end
                    vpcd_pkg::CMD_PLOT, vpcd_pkg::CMD_FILL: begin
                        w_res.opcode = (r_cmd == vpcd_pkg::CMD_PLOT) ?
                                       vpcd_pkg::OP_PLOT : vpcd_pkg::OP_FILL;
                        w_res.x_from = n_slots[1];
                        w_res.y_from = n_slots[0];
                        w_res_valid  = 1'b1;
                        n_pen_x      = n_slots[1];
                        n_pen_y      = n_slots[0];
                        n_idx        = '0;
                        n_taken      = '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // an item with no result never waits for the output register
    assign o_pop = i_qstat.head_valid &&
                   (!w_res_valid || !r_out_valid || o_prim.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd       <= vpcd_pkg::CMD_NONE;
            r_wanted    <= '0;
            r_taken     <= '0;
            r_idx       <= '0;
            r_slots     <= '{default: '0};
            r_pen_x     <= '0;
            r_pen_y     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cmd    <= n_cmd;
                r_wanted <= n_wanted;
                r_taken  <= n_taken;
                r_idx    <= n_idx;
                r_slots  <= n_slots;
                r_pen_x  <= n_pen_x;
                r_pen_y  <= n_pen_y;
            end
            if (o_pop && w_res_valid) begin
                r_out_valid <= 1'b1;
            end else if (o_prim.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_prim.valid  = r_out_valid;
    assign o_prim.opcode = r_out.opcode;
    assign o_prim.x_from = r_out.x_from;
    assign o_prim.y_from = r_out.y_from;
    assign o_prim.x_to   = r_out.x_to;
    assign o_prim.y_to   = r_out.y_to;

endmodule

@@ test/vector_picture_command_decoder_tb.sv @@
// ---------------------------------------------------------------------------
// vector_picture_command_decoder_tb
// Feeds picture command bytes and checks every decoded drawing primitive.
// ---------------------------------------------------------------------------
// A short directed table opens the run and covers the pen resets, chained
// lines, relative moves with wrap, plots, fills, stray command bytes taken
// as data and the end code. Random command sequences follow. Every item
// accepted on the byte channel goes through a local decoder model, and its
// primitives are compared field by field with what o_prim delivers. The
// sender works in bursts and the receiver stalls on a pattern of its own,
// with one long hold-off so that the decoder backs up and stalls its input.
module vector_picture_command_decoder_tb;
    import vpcd_pkg::*;

    localparam int RANDOM_ITEMS = 1500;
    localparam int LONG_HOLD    = 300;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 16;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_END
    } t_row_check;

    typedef struct packed {
        logic [7:0] code;
        t_row_check chk;
    } t_dir_row;

    typedef enum logic [2:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_CHOPPY,
        RX_PATTERN,
        RX_HOLD
    } t_rx_mode;

    localparam t_prim END_PRIM = '{OP_END, 8'h00, 8'h00, 8'h00, 8'h00};

    logic i_clk;
    logic i_rst_n;

    vpcd_byte_if code_if ();
    vpcd_prim_if prim_if ();

    vector_picture_command_decoder uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_code  (code_if),
        .o_prim  (prim_if)
    );

    // directed stream: typed rows are read straight off the decoding rules
    t_dir_row directed_rows [26] = '{
        '{8'hFF, CHK_END},      // end code straight after reset
        '{8'h00, CHK_NONE},     // data before any command is dropped
        '{8'hF3, CHK_NONE},     // non-command code before any command
        '{8'hF6, CHK_MODEL},
        '{8'h00, CHK_MODEL},
        '{8'h00, CHK_MODEL},
        '{8'hFE, CHK_MODEL},
        '{8'hFE, CHK_MODEL},    // line from the origin to the far corner
        '{8'hF1, CHK_MODEL},    // non-command code taken as a y argument
        '{8'h20, CHK_MODEL},    // chained line
        '{8'hF7, CHK_MODEL},    // relative lines keep the pen
        '{8'h88, CHK_MODEL},    // negative zero on both axes
        '{8'h77, CHK_MODEL},    // largest positive step
        '{8'hFA, CHK_MODEL},
        '{8'h05, CHK_MODEL},
        '{8'hF8, CHK_MODEL},    // command code mid-arguments is data
        '{8'hF8, CHK_MODEL},
        '{8'h01, CHK_MODEL},
        '{8'h02, CHK_MODEL},
        '{8'hF6, CHK_MODEL},    // pattern byte, no effect
        '{8'hF7, CHK_MODEL},
        '{8'hFC, CHK_MODEL},    // negative steps wrap below zero
        '{8'hF6, CHK_MODEL},
        '{8'h10, CHK_MODEL},
        '{8'hFF, CHK_END},      // end code mid-arguments
        '{8'h55, CHK_NONE}
    };

    // decoder model state
    t_cmd       pic_cmd;
    logic [2:0] want_cnt;
    logic [2:0] took_cnt;
    logic [2:0] slot_ptr;
    logic [7:0] slots [4];
    logic [7:0] pen_x;
    logic [7:0] pen_y;

    t_prim      expected_prims [$];

    int         fail_count = 0;
    int         total_items;
    int         fed_items;
    int         prims_seen = 0;
    int         kind_count [4] = '{default: 0};
    int         burst_left;
    int         idle_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void clear_decoder();
        pic_cmd  = CMD_NONE;
        want_cnt = '0;
        took_cnt = '0;
        slot_ptr = '0;
        for (int i = 0; i < 4; i++) slots[i] = '0;
        pen_x = '0;
        pen_y = '0;
    endfunction

    function automatic void push_slot(input logic [7:0] v);
        if (slot_ptr < 3'd4) begin
            slots[slot_ptr[1:0]] = v;
            slot_ptr = slot_ptr + 3'd1;
        end
    endfunction

    // bit 3 is the sign, bits 2..0 the magnitude
    function automatic logic [7:0] step_nibble(input logic [7:0] base, input logic [3:0] nib);
        if (nib[3]) return base - {5'b00000, nib[2:0]};
        return base + {5'b00000, nib[2:0]};
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, output t_prim p);
        p = '0;
        if (b == CODE_END) begin
            clear_decoder();
            p.opcode = OP_END;
            return 1'b1;
        end
        if (b > 8'hF0 && took_cnt == 3'd0) begin
            case (b)
                CODE_ABS_LINE: begin
                    pen_x = '0;
                    pen_y = '0;
                    pic_cmd = CMD_ABS;
                    want_cnt = 3'd4;
                    slot_ptr = '0;
                    return 1'b0;
                end
                CODE_REL_LINE: begin
                    pic_cmd = CMD_REL;
                    want_cnt = 3'd1;
                    slot_ptr = '0;
                    push_slot(pen_y);
                    push_slot(pen_x);
                    return 1'b0;
                end
                CODE_PLOT: begin
                    pen_x = '0;
                    pen_y = '0;
                    pic_cmd = CMD_PLOT;
                    want_cnt = 3'd2;
                    slot_ptr = '0;
                    return 1'b0;
                end
                CODE_FILL: begin
                    pen_x = '0;
                    pen_y = '0;
                    pic_cmd = CMD_FILL;
                    want_cnt = 3'd3;
                    slot_ptr = '0;
                    return 1'b0;
                end
                default: ;
            endcase
        end
        if (took_cnt < want_cnt) begin
            if (pic_cmd == CMD_REL) begin
                push_slot(step_nibble(pen_y, b[3:0]));
                push_slot(step_nibble(pen_x, b[7:4]));
                took_cnt = took_cnt + 3'd2;
            end else begin
                push_slot(b);
                took_cnt = took_cnt + 3'd1;
            end
        end
        if (took_cnt < want_cnt) return 1'b0;
        case (pic_cmd)
            CMD_ABS, CMD_REL: begin
                p.opcode = OP_LINE;
                p.x_from = slots[1];
                p.y_from = slots[0];
                p.x_to   = slots[3];
                p.y_to   = slots[2];
                pen_x = slots[3];
                pen_y = slots[2];
                took_cnt = '0;
                slot_ptr = '0;
                // the end point becomes the start of the next chained line
                push_slot(pen_y);
                push_slot(pen_x);
                want_cnt = 3'd2;
                return 1'b1;
            end
            CMD_PLOT, CMD_FILL: begin
                pen_x = slots[1];
                pen_y = slots[0];
                p.opcode = (pic_cmd == CMD_PLOT) ? OP_PLOT : OP_FILL;
                p.x_from = pen_x;
                p.y_from = pen_y;
                slot_ptr = '0;
                took_cnt = '0;
                want_cnt = (pic_cmd == CMD_PLOT) ? 3'd2 : 3'd3;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // argument bytes, now and then from the command code range
    function automatic logic [7:0] arg_byte();
        if ($urandom_range(0, 7) == 0) return 8'($urandom_range(8'hF0, 8'hFE));
        return 8'($urandom_range(0, 8'hFE));
    endfunction

    task automatic send_code(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            // every fourth stretch of 256 items runs without gaps
            if ((total_items / 256) % 4 == 3) gap = 0;
            if (gap != 0) begin
                code_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        code_if.valid     <= 1'b1;
        code_if.code_byte <= b;
        do @(posedge i_clk); while (!code_if.ready);
    endtask

    task automatic feed_byte(input logic [7:0] b, input t_row_check chk);
        t_prim p;
        bit    has;
        bit    dropped;
        send_code(b);
        total_items++;
        dropped = (pic_cmd == CMD_NONE) &&
                  !(b inside {CODE_ABS_LINE, CODE_REL_LINE, CODE_PLOT, CODE_FILL, CODE_END});
        has = decode_byte(b, p);
        if (!dropped) fed_items++;
        case (chk)
            CHK_MODEL: if (has) expected_prims.push_back(p);
            CHK_END:   expected_prims.push_back(END_PRIM);
            default:   ;
        endcase
    endtask

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : prim_check
        t_prim want;
        if (i_rst_n && prim_if.valid && prim_if.ready) begin
            prims_seen++;
            kind_count[prim_if.opcode]++;
            if (expected_prims.size() == 0) begin
                $error("primitive with no item pending: opcode %0d", prim_if.opcode);
                fail_count++;
            end else begin
                want = expected_prims.pop_front();
                check_field("opcode", {6'b0, want.opcode}, {6'b0, prim_if.opcode});
                check_field("x_from", want.x_from, prim_if.x_from);
                check_field("y_from", want.y_from, prim_if.y_from);
                check_field("x_to", want.x_to, prim_if.x_to);
                check_field("y_to", want.y_to, prim_if.y_to);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((code_if.valid && code_if.ready) || (prim_if.valid && prim_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : watchdog
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("vector_picture_command_decoder test failed");
        $finish;
    end

    initial begin : receiver
        t_rx_mode    mode;
        int unsigned span;
        int unsigned seg;
        int unsigned tick;
        prim_if.ready <= 1'b0;
        seg  = 0;
        tick = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            // the third stretch is the long hold-off that backs up the input
            if (seg == 2) begin
                mode = RX_HOLD;
                span = LONG_HOLD;
            end else begin
                mode = t_rx_mode'($urandom_range(0, 4));
                span = (mode == RX_HOLD) ? $urandom_range(8, 40) : $urandom_range(16, 160);
            end
            seg++;
            repeat (span) begin
                @(posedge i_clk);
                tick++;
                case (mode)
                    RX_OPEN:    prim_if.ready <= 1'b1;
                    RX_RANDOM:  prim_if.ready <= ($urandom_range(0, 3) != 0);
                    RX_CHOPPY:  prim_if.ready <= 1'($urandom_range(0, 1));
                    RX_PATTERN: prim_if.ready <= ((tick % 7) < 3);
                    default:    prim_if.ready <= 1'b0;
                endcase
            end
        end
    end

    initial begin : stimulus
        logic [7:0]  stream [$];
        int unsigned pick;
        int unsigned reps;
        total_items = 0;
        fed_items   = 0;
        burst_left  = 0;
        clear_decoder();
        code_if.valid     <= 1'b0;
        code_if.code_byte <= 8'h00;
        i_rst_n           <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) feed_byte(directed_rows[i].code, directed_rows[i].chk);

        // mostly well-formed command runs with random arguments
        fed_items = 0;
        while (fed_items < RANDOM_ITEMS) begin
            if (stream.size() == 0) begin
                pick = $urandom_range(0, 99);
                if (pick < 22) begin
                    stream.push_back(CODE_ABS_LINE);
                    reps = 4 + 2 * $urandom_range(0, 3);
                end else if (pick < 42) begin
                    stream.push_back(CODE_REL_LINE);
                    reps = $urandom_range(1, 6);
                end else if (pick < 57) begin
                    stream.push_back(CODE_PLOT);
                    reps = 2 * $urandom_range(1, 4);
                end else if (pick < 72) begin
                    stream.push_back(CODE_FILL);
                    reps = 3 * $urandom_range(1, 3);
                end else if (pick < 80) begin
                    stream.push_back(CODE_END);
                    reps = 0;
                end else if (pick < 90) begin
                    // may be cut short, so the next run's command can land mid-arguments
                    case ($urandom_range(0, 3))
                        0:       stream.push_back(CODE_ABS_LINE);
                        1:       stream.push_back(CODE_REL_LINE);
                        2:       stream.push_back(CODE_PLOT);
                        default: stream.push_back(CODE_FILL);
                    endcase
                    reps = $urandom_range(1, 3);
                end else begin
                    reps = 0;
                    repeat ($urandom_range(1, 4)) stream.push_back(8'($urandom_range(0, 255)));
                end
                repeat (reps) stream.push_back(arg_byte());
            end
            feed_byte(stream.pop_front(), CHK_MODEL);
        end
        code_if.valid <= 1'b0;

        while (expected_prims.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("fed %0d bytes, %0d of them past the idle state in the random part",
                 total_items, fed_items);
        $display("checked %0d primitives: %0d lines, %0d plots, %0d fills, %0d ends",
                 prims_seen, kind_count[OP_LINE], kind_count[OP_PLOT],
                 kind_count[OP_FILL], kind_count[OP_END]);
        if (fail_count == 0) begin
            $display("vector_picture_command_decoder test passed");
        end else begin
            $display("vector_picture_command_decoder test failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/vpcd_pkg.sv
hw/rtl/vpcd_byte_if.sv
hw/rtl/vpcd_prim_if.sv
hw/rtl/vpcd_front.sv
hw/rtl/vpcd_queue.sv
hw/rtl/vpcd_back.sv
hw/rtl/vector_picture_command_decoder.sv
test/vector_picture_command_decoder_tb.sv
